// ===== rtl/npf_pkg.sv =====
`timescale 1ns / 1ps
// shared types, codes and constants of the neighbour packet plausibility filter
// used by npf_ctrl, npf_dp and the top level; no dependencies

package npf_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int SLOT_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [31:0] MS_PER_S     = 32'd1000;
  localparam logic [31:0] SPEED_SCALE  = 32'd1000000;
  localparam logic [15:0] SEQ_WINDOW   = 16'd1000;

  // configuration register indexes
  localparam logic [1:0] REG_VERSION = 2'd0;
  localparam logic [1:0] REG_MIN_GAP = 2'd1;
  localparam logic [1:0] REG_JUMP    = 2'd2;
  localparam logic [1:0] REG_SPEED   = 2'd3;

  // verdict codes
  localparam logic [3:0] V_OK      = 4'd0;
  localparam logic [3:0] V_NEW     = 4'd1;
  localparam logic [3:0] V_VERSION = 4'd2;
  localparam logic [3:0] V_FULL    = 4'd3;
  localparam logic [3:0] V_RATE    = 4'd4;
  localparam logic [3:0] V_SEQ     = 4'd5;
  localparam logic [3:0] V_TIME    = 4'd6;
  localparam logic [3:0] V_JUMP    = 4'd7;
  localparam logic [3:0] V_SPEED   = 4'd8;

  // datapath operations
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_SRCH   = 5'd2;
  localparam logic [4:0] OP_STORE  = 5'd3;
  localparam logic [4:0] OP_READ   = 5'd4;
  localparam logic [4:0] OP_MT_NEW = 5'd5;
  localparam logic [4:0] OP_MT_OLD = 5'd6;
  localparam logic [4:0] OP_DT     = 5'd7;
  localparam logic [4:0] OP_SQX    = 5'd8;
  localparam logic [4:0] OP_SQY    = 5'd9;
  localparam logic [4:0] OP_SQZ    = 5'd10;
  localparam logic [4:0] OP_SQE    = 5'd11;
  localparam logic [4:0] OP_PLO    = 5'd12;
  localparam logic [4:0] OP_PHI    = 5'd13;
  localparam logic [4:0] OP_PSUM   = 5'd14;
  localparam logic [4:0] OP_L0     = 5'd15;
  localparam logic [4:0] OP_L1     = 5'd16;
  localparam logic [4:0] OP_L2     = 5'd17;
  localparam logic [4:0] OP_L3     = 5'd18;
  localparam logic [4:0] OP_V1     = 5'd19;
  localparam logic [4:0] OP_V2     = 5'd20;
  localparam logic [4:0] OP_V3     = 5'd21;
  localparam logic [4:0] OP_FIN    = 5'd22;

  typedef struct packed {
    logic        [47:0] node_address;
    logic        [7:0]  proto_version;
    logic        [15:0] sequence_req;
    logic        [31:0] stamp_seconds;
    logic        [15:0] stamp_millis;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic        [31:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic       accepted;
    logic [3:0] verdict;
  } out_item_t;

  typedef struct packed {
    logic [47:0] addr;
    logic [31:0] tick;
    logic [15:0] seq;
    logic [31:0] sec;
    logic [15:0] ms;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } slot_t;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] verdict;
  } cmd_t;

  typedef struct packed {
    logic ver_bad;
    logic hit_now;
    logic srch_last;
    logic free_any;
    logic rate_bad;
    logic seq_bad;
    logic time_bad;
    logic dt_one;
    logic jump_bad;
    logic p_big;
    logic speed_bad;
    logic out_free;
  } status_t;

endpackage

// ===== rtl/npf_ctrl.sv =====
`timescale 1ns / 1ps
// controller state machine: sequences search, checks and multiplier steps
// depends on npf_pkg; drives npf_dp through cmd_t, reads status_t

module npf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  npf_pkg::status_t st,
  output npf_pkg::cmd_t    cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_VER   = 5'd1;
  localparam logic [4:0] S_SRCH  = 5'd2;
  localparam logic [4:0] S_READ  = 5'd3;
  localparam logic [4:0] S_GAP   = 5'd4;
  localparam logic [4:0] S_MTOLD = 5'd5;
  localparam logic [4:0] S_DT    = 5'd6;
  localparam logic [4:0] S_TCHK  = 5'd7;
  localparam logic [4:0] S_SQY   = 5'd8;
  localparam logic [4:0] S_SQZ   = 5'd9;
  localparam logic [4:0] S_SQE   = 5'd10;
  localparam logic [4:0] S_JCHK  = 5'd11;
  localparam logic [4:0] S_PHI   = 5'd12;
  localparam logic [4:0] S_PSUM  = 5'd13;
  localparam logic [4:0] S_PCHK  = 5'd14;
  localparam logic [4:0] S_L1    = 5'd15;
  localparam logic [4:0] S_L2    = 5'd16;
  localparam logic [4:0] S_L3    = 5'd17;
  localparam logic [4:0] S_V1    = 5'd18;
  localparam logic [4:0] S_V2    = 5'd19;
  localparam logic [4:0] S_V3    = 5'd20;
  localparam logic [4:0] S_SCHK  = 5'd21;
  localparam logic [4:0] S_STORE = 5'd22;
  localparam logic [4:0] S_FIN   = 5'd23;

  logic [4:0] state, state_next;
  logic [3:0] verdict, verdict_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    verdict_next = verdict;
    cmd.op       = npf_pkg::OP_NONE;
    cmd.verdict  = verdict;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = npf_pkg::OP_LOAD;
          state_next = S_VER;
        end
      end
      S_VER: begin
        if (st.ver_bad) begin
          verdict_next = npf_pkg::V_VERSION;
          state_next   = S_FIN;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_SRCH: begin
        cmd.op = npf_pkg::OP_SRCH;
        priority if (st.hit_now) begin
          state_next = S_READ;
        end else if (st.srch_last && st.free_any) begin
          verdict_next = npf_pkg::V_NEW;
          state_next   = S_STORE;
        end else if (st.srch_last) begin
          verdict_next = npf_pkg::V_FULL;
          state_next   = S_FIN;
        end else begin
          state_next = S_SRCH;
        end
      end
      S_READ: begin
        cmd.op     = npf_pkg::OP_READ;
        state_next = S_GAP;
      end
      S_GAP: begin
        cmd.op = npf_pkg::OP_MT_NEW;
        priority if (st.rate_bad) begin
          verdict_next = npf_pkg::V_RATE;
          state_next   = S_FIN;
        end else if (st.seq_bad) begin
          verdict_next = npf_pkg::V_SEQ;
          state_next   = S_FIN;
        end else begin
          state_next = S_MTOLD;
        end
      end
      S_MTOLD: begin
        cmd.op     = npf_pkg::OP_MT_OLD;
        state_next = S_DT;
      end
      S_DT: begin
        cmd.op     = npf_pkg::OP_DT;
        state_next = S_TCHK;
      end
      S_TCHK: begin
        cmd.op = npf_pkg::OP_SQX;
        if (st.time_bad) begin
          verdict_next = npf_pkg::V_TIME;
          state_next   = S_FIN;
        end else begin
          state_next = S_SQY;
        end
      end
      S_SQY: begin
        cmd.op     = npf_pkg::OP_SQY;
        state_next = S_SQZ;
      end
      S_SQZ: begin
        cmd.op     = npf_pkg::OP_SQZ;
        state_next = S_SQE;
      end
      S_SQE: begin
        cmd.op     = npf_pkg::OP_SQE;
        state_next = S_JCHK;
      end
      S_JCHK: begin
        cmd.op = npf_pkg::OP_PLO;
        priority if (st.dt_one && st.jump_bad) begin
          verdict_next = npf_pkg::V_JUMP;
          state_next   = S_FIN;
        end else if (st.dt_one) begin
          verdict_next = npf_pkg::V_OK;
          state_next   = S_STORE;
        end else begin
          state_next = S_PHI;
        end
      end
      S_PHI: begin
        cmd.op     = npf_pkg::OP_PHI;
        state_next = S_PSUM;
      end
      S_PSUM: begin
        cmd.op     = npf_pkg::OP_PSUM;
        state_next = S_PCHK;
      end
      S_PCHK: begin
        cmd.op = npf_pkg::OP_L0;
        // limit times gap beyond 2^44 can never be exceeded
        if (st.p_big) begin
          verdict_next = npf_pkg::V_OK;
          state_next   = S_STORE;
        end else begin
          state_next = S_L1;
        end
      end
      S_L1: begin
        cmd.op     = npf_pkg::OP_L1;
        state_next = S_L2;
      end
      S_L2: begin
        cmd.op     = npf_pkg::OP_L2;
        state_next = S_L3;
      end
      S_L3: begin
        cmd.op     = npf_pkg::OP_L3;
        state_next = S_V1;
      end
      S_V1: begin
        cmd.op     = npf_pkg::OP_V1;
        state_next = S_V2;
      end
      S_V2: begin
        cmd.op     = npf_pkg::OP_V2;
        state_next = S_V3;
      end
      S_V3: begin
        cmd.op     = npf_pkg::OP_V3;
        state_next = S_SCHK;
      end
      S_SCHK: begin
        if (st.speed_bad) begin
          verdict_next = npf_pkg::V_SPEED;
          state_next   = S_FIN;
        end else begin
          verdict_next = npf_pkg::V_OK;
          state_next   = S_STORE;
        end
      end
      S_STORE: begin
        cmd.op     = npf_pkg::OP_STORE;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.op     = npf_pkg::OP_FIN;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      verdict <= npf_pkg::V_OK;
    end else begin
      state   <= state_next;
      verdict <= verdict_next;
    end
  end

endmodule

// ===== rtl/npf_dp.sv =====
`timescale 1ns / 1ps
// datapath: config registers, node table, shared 32x32 multiplier, result register
// depends on npf_pkg; commanded by npf_ctrl

module npf_dp (
  input  logic               clk,
  input  logic               rst,
  input  npf_pkg::cmd_t      cmd,
  output npf_pkg::status_t   st,
  input  npf_pkg::in_item_t  in_data,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_ready,
  output npf_pkg::out_item_t out_data
);

  logic [7:0]  expected_version;
  logic [31:0] min_gap_ticks;
  logic [31:0] jump_tolerance_mm;
  logic [31:0] speed_limit_mm_s;

  logic [npf_pkg::TABLE_ENTRIES-1:0] valid;
  npf_pkg::slot_t table_q [npf_pkg::TABLE_ENTRIES];

  npf_pkg::in_item_t        item;
  npf_pkg::slot_t           rd;
  npf_pkg::slot_t           cur;
  logic [npf_pkg::SLOT_W-1:0] idx;
  logic [npf_pkg::SLOT_W-1:0] free_idx;
  logic [npf_pkg::SLOT_W-1:0] store_idx;
  logic                     hit;
  logic                     free_found;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [42:0] t_new;
  logic [42:0] t_old;
  logic [43:0] dt_diff;
  logic [42:0] dt;
  logic        time_bad;
  logic [65:0] dist_sq;
  logic [75:0] pw;
  logic [87:0] lim;
  logic [87:0] vel;
  logic [31:0] ax, ay, az;
  logic [31:0] tick_gap;
  logic [15:0] seq_drop;

  function automatic logic [31:0] abs_diff(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] d;
    d = {a[31], a} - {b[31], b};
    abs_diff = d[32] ? 32'(-d) : d[31:0];
  endfunction

  assign cur       = table_q[idx];
  assign store_idx = hit ? idx : free_idx;
  assign ax        = abs_diff(item.pos_x, rd.x);
  assign ay        = abs_diff(item.pos_y, rd.y);
  assign az        = abs_diff(item.pos_z, rd.z);
  assign tick_gap  = item.now_ticks - rd.tick;
  assign seq_drop  = rd.seq - item.sequence_req;
  assign t_old     = 43'(prod) + 43'(rd.ms);
  assign dt_diff   = {1'b0, t_new} - {1'b0, t_old};

  // status toward the controller
  always_comb begin
    st.ver_bad   = (item.proto_version != expected_version);
    st.hit_now   = valid[idx] && (cur.addr == item.node_address);
    st.srch_last = (idx == npf_pkg::SLOT_W'(npf_pkg::TABLE_ENTRIES - 1));
    st.free_any  = free_found || !valid[idx];
    st.rate_bad  = (tick_gap < min_gap_ticks);
    st.seq_bad   = (item.sequence_req <= rd.seq) && (seq_drop < npf_pkg::SEQ_WINDOW);
    st.time_bad  = time_bad;
    st.dt_one    = (dt == 43'd1);
    st.jump_bad  = (dist_sq > 66'(prod));
    st.p_big     = |pw[75:44];
    st.speed_bad = (vel > lim);
    st.out_free  = !out_valid || out_ready;
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      npf_pkg::OP_MT_NEW: begin mul_a = item.stamp_seconds; mul_b = npf_pkg::MS_PER_S; end
      npf_pkg::OP_MT_OLD: begin mul_a = rd.sec;             mul_b = npf_pkg::MS_PER_S; end
      npf_pkg::OP_SQX:    begin mul_a = ax; mul_b = ax; end
      npf_pkg::OP_SQY:    begin mul_a = ay; mul_b = ay; end
      npf_pkg::OP_SQZ:    begin mul_a = az; mul_b = az; end
      npf_pkg::OP_SQE:    begin mul_a = jump_tolerance_mm; mul_b = jump_tolerance_mm; end
      npf_pkg::OP_PLO:    begin mul_a = speed_limit_mm_s; mul_b = dt[31:0]; end
      npf_pkg::OP_PHI:    begin mul_a = speed_limit_mm_s; mul_b = 32'(dt[42:32]); end
      npf_pkg::OP_L0:     begin mul_a = pw[31:0]; mul_b = pw[31:0]; end
      npf_pkg::OP_L1:     begin mul_a = pw[31:0]; mul_b = 32'(pw[43:32]); end
      npf_pkg::OP_L2:     begin mul_a = 32'(pw[43:32]); mul_b = 32'(pw[43:32]); end
      npf_pkg::OP_L3:     begin mul_a = dist_sq[31:0]; mul_b = npf_pkg::SPEED_SCALE; end
      npf_pkg::OP_V1:     begin mul_a = dist_sq[63:32]; mul_b = npf_pkg::SPEED_SCALE; end
      npf_pkg::OP_V2:     begin mul_a = 32'(dist_sq[65:64]); mul_b = npf_pkg::SPEED_SCALE; end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    unique case (cmd.op)
      npf_pkg::OP_LOAD:   item  <= in_data;
      npf_pkg::OP_READ:   rd    <= cur;
      npf_pkg::OP_MT_OLD: t_new <= 43'(prod) + 43'(item.stamp_millis);
      npf_pkg::OP_DT: begin
        dt       <= dt_diff[42:0];
        time_bad <= dt_diff[43] || (dt_diff[42:0] == 43'd0);
      end
      npf_pkg::OP_SQY:  dist_sq <= 66'(prod);
      npf_pkg::OP_SQZ:  dist_sq <= dist_sq + 66'(prod);
      npf_pkg::OP_SQE:  dist_sq <= dist_sq + 66'(prod);
      npf_pkg::OP_PHI:  pw   <= 76'(prod);
      npf_pkg::OP_PSUM: pw   <= pw + (76'(prod) << 32);
      npf_pkg::OP_L1:   lim  <= 88'(prod);
      npf_pkg::OP_L2:   lim  <= lim + (88'(prod) << 33);
      npf_pkg::OP_L3:   lim  <= lim + (88'(prod) << 64);
      npf_pkg::OP_V1:   vel  <= 88'(prod);
      npf_pkg::OP_V2:   vel  <= vel + (88'(prod) << 32);
      npf_pkg::OP_V3:   vel  <= vel + (88'(prod) << 64);
      npf_pkg::OP_STORE: begin
        table_q[store_idx] <= '{addr: item.node_address, tick: item.now_ticks,
                                seq: item.sequence_req, sec: item.stamp_seconds,
                                ms: item.stamp_millis, x: item.pos_x,
                                y: item.pos_y, z: item.pos_z};
      end
      default: begin
      end
    endcase
  end

  // control state: search bookkeeping, valid bits, config, result register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_version  <= 8'd1;
      min_gap_ticks     <= 32'd10;
      jump_tolerance_mm <= 32'd1000;
      speed_limit_mm_s  <= 32'd10000;
      valid             <= '0;
      idx               <= '0;
      free_idx          <= '0;
      hit               <= 1'b0;
      free_found        <= 1'b0;
      out_valid         <= 1'b0;
      out_data          <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          npf_pkg::REG_VERSION: expected_version  <= cfg_data[7:0];
          npf_pkg::REG_MIN_GAP: min_gap_ticks     <= cfg_data;
          npf_pkg::REG_JUMP:    jump_tolerance_mm <= cfg_data;
          npf_pkg::REG_SPEED:   speed_limit_mm_s  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.op == npf_pkg::OP_FIN) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        npf_pkg::OP_LOAD: begin
          idx        <= '0;
          hit        <= 1'b0;
          free_found <= 1'b0;
        end
        npf_pkg::OP_SRCH: begin
          // idx stays on the matching slot so later reads and the update use it
          if (st.hit_now) begin
            hit <= 1'b1;
          end else begin
            if (!valid[idx] && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= idx;
            end
            idx <= idx + 1'b1;
          end
        end
        npf_pkg::OP_STORE: valid[store_idx] <= 1'b1;
        npf_pkg::OP_FIN: begin
          out_data.verdict  <= cmd.verdict;
          out_data.accepted <= (cmd.verdict == npf_pkg::V_OK) ||
                               (cmd.verdict == npf_pkg::V_NEW);
        end
        default: begin
        end
      endcase
    end
  end

  a_store_has_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.op == npf_pkg::OP_STORE |-> hit || free_found)
    else $error("table update without a matching or free slot");

  a_fin_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.op == npf_pkg::OP_FIN |-> !out_valid || out_ready)
    else $error("result written over one not yet taken");

  a_load_clears_search: assert property (@(posedge clk) disable iff (rst)
    cmd.op == npf_pkg::OP_LOAD |=> !hit && !free_found && idx == '0)
    else $error("search state not cleared on a new report");

  a_hit_idx_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.op == npf_pkg::OP_READ |-> hit && valid[idx])
    else $error("slot read without a valid hit");

endmodule

// ===== rtl/neighbour_packet_plausibility_filter_top.sv =====
`timescale 1ns / 1ps
// top level of the neighbour packet plausibility filter
// depends on npf_pkg, npf_ctrl and npf_dp

// One report is handled at a time. A report from a known node searches the
// table up to its matching slot and then runs the checks, ending with the
// full speed check where the earlier checks leave it open; a new or
// full-table report searches every slot, and a version reject skips the
// search. The run time is set by the one-slot-per-cycle table search and by the single
// shared 32x32 multiplier that forms the timestamps, the squared distance and
// the squared speed bound in turn. A finished result waits in an output
// register, and a new report is taken as soon as the previous one is written
// there. The table's valid bits clear in the reset cycle itself; configuration
// writes are always taken and must only be made while the block is idle.

module neighbour_packet_plausibility_filter_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  npf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output npf_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  npf_pkg::cmd_t    cmd;
  npf_pkg::status_t st;

  assign cfg_ready = 1'b1;

  npf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  npf_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
